### hdl/bellman_ford_shortest_paths_defines.svh
// Assertion macros shared by the RTL files.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_DEFINES_SVH
`ifndef ASSERT_OFF
`define BF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bfsp assertion failed");
`define BF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bfsp reset assertion failed");
`else
`define BF_ASSERT(lbl, prop)
`define BF_ASSERT_RST(lbl, prop)
`endif
`endif

### hdl/bfsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfsp_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 256;

  localparam int REQ_W      = 2;
  localparam int VTX_W      = 6;
  localparam int WGT_W      = 16;
  localparam int OUT_DIST_W = 22;
  localparam int CFG_W      = 7;
  localparam int EDGE_W     = 2 * VTX_W + WGT_W;

  localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RUN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLR = 2'd2;

  typedef struct packed {
    logic add_edge;
    logic clr_table;
    logic start;
    logic dist_rd;
    logic relax;
    logic next_pass;
    logic out_rd;
    logic out_load;
    logic v_inc;
    logic neg_load;
  } cmd_t;

  typedef struct packed {
    logic edge_end;
    logic check_pass;
    logic changed;
    logic out_free;
    logic v_last;
  } sts_t;

endpackage
`default_nettype wire

### hdl/bfsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hdl/bfsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bellman_ford_shortest_paths_defines.svh"
module bfsp_ctrl
  import bfsp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [REQ_W-1:0] in_req_type,
  output logic                  in_stall,
  input  wire sts_t             sts_i,
  output cmd_t                  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_RELAX  = 3'd3;
  localparam logic [2:0] S_OUT_RD = 3'd4;
  localparam logic [2:0] S_OUT_LD = 3'd5;
  localparam logic [2:0] S_NEG    = 3'd6;

  logic [2:0] state_r, state_nxt;
  cmd_t       cmd;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req_type)
            REQ_ADD: cmd.add_edge = 1'b1;
            REQ_CLR: cmd.clr_table = 1'b1;
            REQ_RUN: begin
              cmd.start = 1'b1;
              state_nxt = S_FETCH;
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        if (sts_i.edge_end) begin
          if (sts_i.check_pass) begin
            state_nxt = sts_i.changed ? S_NEG : S_OUT_RD;
          end else begin
            cmd.next_pass = 1'b1;
          end
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.dist_rd = 1'b1;
        state_nxt   = S_RELAX;
      end
      S_RELAX: begin
        cmd.relax = 1'b1;
        state_nxt = S_FETCH;
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_rd = 1'b1;
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          if (sts_i.v_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.v_inc = 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      S_NEG: begin
        if (sts_i.out_free) begin
          cmd.neg_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign cmd_o    = cmd;

  `BF_ASSERT_RST(a_reset_idle, !rst_n |=> state_r == S_IDLE)
  `BF_ASSERT(a_run_starts, (in_valid && !in_stall && in_req_type == REQ_RUN) |=> state_r == S_FETCH)
  `BF_ASSERT(a_load_free, (cmd.out_load || cmd.neg_load) |-> sts_i.out_free)

endmodule
`default_nettype wire

### hdl/bfsp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bellman_ford_shortest_paths_defines.svh"
module bfsp_dp
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cmd_t                         cmd_i,
  output sts_t                              sts_o,
  input  wire logic                         cfg_valid,
  input  wire logic        [CFG_W-1:0]      cfg_data,
  input  wire logic        [VTX_W-1:0]      in_edge_from,
  input  wire logic        [VTX_W-1:0]      in_edge_to,
  input  wire logic signed [WGT_W-1:0]      in_edge_weight,
  input  wire logic        [VTX_W-1:0]      in_source_vertex,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [VTX_W-1:0]      out_vertex,
  output logic signed      [OUT_DIST_W-1:0] out_distance,
  output logic                              out_reachable,
  output logic                              out_negative_cycle,
  output logic                              out_last
);

  localparam int VI_W   = $clog2(MAX_VERTICES);
  localparam int N_W    = $clog2(MAX_VERTICES + 1);
  localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W   = $clog2(MAX_EDGES + 1);
  localparam int DIST_W = $clog2(MAX_VERTICES * MAX_EDGES + 1) + WGT_W + 1;
  localparam int CMP_W  = VTX_W + 1;

  logic [CFG_W-1:0]  vcount_r;
  logic [N_W-1:0]    n_act, n_r, pass_r;
  logic [EC_W-1:0]   edge_cnt_r, e_r;
  logic [VI_W-1:0]   v_r;
  logic [MAX_VERTICES-1:0] reach_r, reach_nxt;
  logic              changed_r;

  logic [EDGE_W-1:0] edge_wdata, edge_q;
  logic              edge_we;
  logic [VTX_W-1:0]  e_from, e_to;
  logic signed [WGT_W-1:0] e_wgt;
  logic [VI_W-1:0]   from_idx, to_idx, src_idx, rda_addr, dist_waddr;
  logic [DIST_W-1:0] da_q, db_q, dist_wdata;
  logic              dist_we;
  logic signed [DIST_W-1:0] cand;
  logic              in_rng, ra, rb, do_relax, out_free;

  logic              out_valid_r;
  logic [VTX_W-1:0]  out_vertex_r;
  logic signed [OUT_DIST_W-1:0] out_distance_r;
  logic              out_reachable_r, out_neg_r, out_last_r;

  always_comb begin
    if (vcount_r == '0) begin
      n_act = N_W'(1);
    end else if (vcount_r > CFG_W'(MAX_VERTICES)) begin
      n_act = N_W'(MAX_VERTICES);
    end else begin
      n_act = N_W'(vcount_r);
    end
  end

  assign edge_we    = cmd_i.add_edge && (edge_cnt_r < EC_W'(MAX_EDGES));
  assign edge_wdata = {in_edge_from, in_edge_to, in_edge_weight};

  bfsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_cnt_r[EA_W-1:0]),
    .wdata (edge_wdata),
    .raddr (e_r[EA_W-1:0]),
    .rdata (edge_q)
  );

  assign e_from   = edge_q[EDGE_W-1 -: VTX_W];
  assign e_to     = edge_q[WGT_W +: VTX_W];
  assign e_wgt    = $signed(edge_q[WGT_W-1:0]);
  assign from_idx = e_from[VI_W-1:0];
  assign to_idx   = e_to[VI_W-1:0];
  assign src_idx  = in_source_vertex[VI_W-1:0];

  assign in_rng   = ({1'b0, e_from} < CMP_W'(n_r)) && ({1'b0, e_to} < CMP_W'(n_r));
  assign ra       = in_rng && reach_r[from_idx];
  assign rb       = in_rng && reach_r[to_idx];
  assign cand     = $signed(da_q) + DIST_W'(e_wgt);
  assign do_relax = ra && (!rb || (cand < $signed(db_q)));

  assign rda_addr   = cmd_i.out_rd ? v_r : from_idx;
  assign dist_we    = cmd_i.start || (cmd_i.relax && do_relax);
  assign dist_waddr = cmd_i.start ? src_idx : to_idx;
  assign dist_wdata = cmd_i.start ? '0 : DIST_W'(cand);

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram_a (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (rda_addr),
    .rdata (da_q)
  );

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram_b (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (to_idx),
    .rdata (db_q)
  );

  always_comb begin
    reach_nxt = reach_r;
    if (cmd_i.start) begin
      reach_nxt = '0;
      if ({1'b0, in_source_vertex} < CMP_W'(n_act)) begin
        reach_nxt[src_idx] = 1'b1;
      end
    end else if (cmd_i.relax && do_relax) begin
      reach_nxt[to_idx] = 1'b1;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= CFG_W'(1);
      edge_cnt_r  <= '0;
      e_r         <= '0;
      pass_r      <= '0;
      v_r         <= '0;
      n_r         <= N_W'(1);
      reach_r     <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      reach_r <= reach_nxt;
      if (cfg_valid) begin
        vcount_r <= cfg_data;
      end
      if (cmd_i.clr_table) begin
        edge_cnt_r <= '0;
      end else if (edge_we) begin
        edge_cnt_r <= edge_cnt_r + EC_W'(1);
      end
      if (cmd_i.start) begin
        n_r       <= n_act;
        pass_r    <= N_W'(1);
        e_r       <= '0;
        v_r       <= '0;
        changed_r <= 1'b0;
      end else if (cmd_i.next_pass) begin
        pass_r    <= pass_r + N_W'(1);
        e_r       <= '0;
        changed_r <= 1'b0;
      end else if (cmd_i.relax) begin
        e_r <= e_r + EC_W'(1);
        if (do_relax) begin
          changed_r <= 1'b1;
        end
      end
      if (cmd_i.v_inc) begin
        v_r <= v_r + VI_W'(1);
      end
      if (cmd_i.out_load || cmd_i.neg_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_vertex_r    <= VTX_W'(v_r);
      out_distance_r  <= reach_r[v_r] ? OUT_DIST_W'($signed(da_q)) : '0;
      out_reachable_r <= reach_r[v_r];
      out_neg_r       <= 1'b0;
      out_last_r      <= sts_o.v_last;
    end else if (cmd_i.neg_load) begin
      out_vertex_r    <= '0;
      out_distance_r  <= '0;
      out_reachable_r <= 1'b0;
      out_neg_r       <= 1'b1;
      out_last_r      <= 1'b1;
    end
  end

  assign sts_o.edge_end   = (e_r == edge_cnt_r);
  assign sts_o.check_pass = (pass_r == n_r);
  assign sts_o.changed    = changed_r;
  assign sts_o.out_free   = out_free;
  assign sts_o.v_last     = ((N_W'(v_r) + N_W'(1)) == n_r);

  assign out_valid          = out_valid_r;
  assign out_vertex         = out_vertex_r;
  assign out_distance       = out_distance_r;
  assign out_reachable      = out_reachable_r;
  assign out_negative_cycle = out_neg_r;
  assign out_last           = out_last_r;

  `BF_ASSERT(a_cnt_bound, edge_cnt_r <= EC_W'(MAX_EDGES))
  `BF_ASSERT(a_relax_in_pass, cmd_i.relax |-> (e_r < edge_cnt_r) && (pass_r <= n_r))
  `BF_ASSERT(a_out_vertex_range, cmd_i.out_load |-> N_W'(v_r) < n_r)

endmodule
`default_nettype wire

### hdl/bellman_ford_shortest_paths.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   req_type, edge_from, edge_to, edge_weight,
//                                         source_vertex
// out_     output     out_valid/out_stall vertex, distance, reachable, negative_cycle, last
// cfg_     input      cfg_valid/cfg_ready data = vertex_count
//
// Add-edge and clear items are accepted back to back while the block is idle.
// A run makes n passes over the E stored edges for n vertices, the last a check pass: each
// edge relaxation is a fetch, a distance read and an add/compare/write on the shared RAMs.
// Results then follow one per vertex, or a single negative_cycle result, held by out_stall.
// Synchronous active-low reset empties the edge table and sets vertex_count to 1.
// in_stall is high from the accepted run item until its last result is loaded.
`timescale 1ns / 1ps
`default_nettype none
module bellman_ford_shortest_paths
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic        [CFG_W-1:0]      cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic        [REQ_W-1:0]      in_req_type,
  input  wire logic        [VTX_W-1:0]      in_edge_from,
  input  wire logic        [VTX_W-1:0]      in_edge_to,
  input  wire logic signed [WGT_W-1:0]      in_edge_weight,
  input  wire logic        [VTX_W-1:0]      in_source_vertex,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [VTX_W-1:0]      out_vertex,
  output logic signed      [OUT_DIST_W-1:0] out_distance,
  output logic                              out_reachable,
  output logic                              out_negative_cycle,
  output logic                              out_last
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bfsp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfsp_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .in_edge_from       (in_edge_from),
    .in_edge_to         (in_edge_to),
    .in_edge_weight     (in_edge_weight),
    .in_source_vertex   (in_source_vertex),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_vertex         (out_vertex),
    .out_distance       (out_distance),
    .out_reachable      (out_reachable),
    .out_negative_cycle (out_negative_cycle),
    .out_last           (out_last)
  );

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bfsp_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 48;
  localparam int FILL_ITEMS    = DEF_MAX_EDGES + 3;
  localparam int HOLD_CYCLES   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 64;
  localparam int STALL_LIMIT   = 200000;
  localparam int MAX_REPORTED  = 10;

  typedef struct packed {
    logic [REQ_W-1:0]        req;
    logic [VTX_W-1:0]        tail;
    logic [VTX_W-1:0]        head;
    logic signed [WGT_W-1:0] weight;
    logic [VTX_W-1:0]        src;
  } request_t;

  typedef struct packed {
    logic [VTX_W-1:0]             vertex;
    logic signed [OUT_DIST_W-1:0] distance;
    logic                         reachable;
    logic                         negative_cycle;
    logic                         last;
  } result_t;

  typedef struct packed {
    logic [VTX_W-1:0]        tail;
    logic [VTX_W-1:0]        head;
    logic signed [WGT_W-1:0] weight;
  } edge_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CFG_W-1:0] cfg;
    request_t         rq;
    logic             typed;
    result_t          res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  request_t offered = '0;
  logic offered_typed = 1'b0;
  result_t offered_report = '0;
  logic out_stall = 1'b0;
  logic hold_on = 1'b0;
  bit hold_go = 1'b0;
  int send_idle_pct = 23;
  int recv_idle_pct = 48;

  logic cfg_ready;
  logic in_stall;
  logic out_valid;
  logic [VTX_W-1:0] out_vertex;
  logic signed [OUT_DIST_W-1:0] out_distance;
  logic out_reachable;
  logic out_negative_cycle;
  logic out_last;

  edge_t edge_list [DEF_MAX_EDGES];
  int edge_total = 0;
  logic [CFG_W-1:0] vcount_q = 7'd1;
  longint path_len [DEF_MAX_VERTICES];
  bit reached [DEF_MAX_VERTICES];
  result_t run_reports [$];
  result_t distance_reports [$];

  result_t seen;
  result_t want;
  logic busy;
  int quiet_cycles = 0;
  int mismatches = 0;

  always #2 clk = ~clk;

  bellman_ford_shortest_paths dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (offered.req),
    .in_edge_from       (offered.tail),
    .in_edge_to         (offered.head),
    .in_edge_weight     (offered.weight),
    .in_source_vertex   (offered.src),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_vertex         (out_vertex),
    .out_distance       (out_distance),
    .out_reachable      (out_reachable),
    .out_negative_cycle (out_negative_cycle),
    .out_last           (out_last)
  );

  function automatic bit relax_pass(int n);
    bit improved;
    longint cand;
    improved = 1'b0;
    for (int e = 0; e < edge_total; e++) begin
      if (edge_list[e].tail < n && edge_list[e].head < n && reached[edge_list[e].tail]) begin
        cand = path_len[edge_list[e].tail] + longint'(edge_list[e].weight);
        if (!reached[edge_list[e].head] || cand < path_len[edge_list[e].head]) begin
          path_len[edge_list[e].head] = cand;
          reached[edge_list[e].head] = 1'b1;
          improved = 1'b1;
        end
      end
    end
    return improved;
  endfunction

  function automatic void apply_graph_request(request_t rq);
    int n;
    result_t r;
    edge_t ed;
    run_reports.delete();
    case (rq.req)
      REQ_ADD: begin
        if (edge_total < DEF_MAX_EDGES) begin
          ed.tail = rq.tail;
          ed.head = rq.head;
          ed.weight = rq.weight;
          edge_list[edge_total] = ed;
          edge_total++;
        end
      end
      REQ_CLR: edge_total = 0;
      REQ_RUN: begin
        n = (vcount_q == 0) ? 1 : (vcount_q > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : vcount_q;
        for (int i = 0; i < n; i++) begin
          path_len[i] = 0;
          reached[i] = 1'b0;
        end
        if (rq.src < n) reached[rq.src] = 1'b1;
        for (int i = 1; i < n; i++) void'(relax_pass(n));
        if (relax_pass(n)) begin
          r = '0;
          r.negative_cycle = 1'b1;
          r.last = 1'b1;
          run_reports.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.vertex = VTX_W'(i);
            r.distance = reached[i] ? OUT_DIST_W'(path_len[i]) : '0;
            r.reachable = reached[i];
            r.negative_cycle = 1'b0;
            r.last = (i == n - 1);
            run_reports.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, result_t w, result_t g);
    mismatches++;
    if (mismatches <= MAX_REPORTED)
      $display("%s: want v=%0d d=%0d r=%0b nc=%0b l=%0b, got v=%0d d=%0d r=%0b nc=%0b l=%0b",
               what, w.vertex, w.distance, w.reachable, w.negative_cycle, w.last,
               g.vertex, g.distance, g.reachable, g.negative_cycle, g.last);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready) begin
        vcount_q = cfg_data;
        busy = 1'b1;
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        apply_graph_request(offered);
        if (offered_typed) distance_reports.push_back(offered_report);
        else foreach (run_reports[i]) distance_reports.push_back(run_reports[i]);
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        seen = {out_vertex, out_distance, out_reachable, out_negative_cycle, out_last};
        if (distance_reports.size() == 0) begin
          note_mismatch("unexpected result", '0, seen);
        end else begin
          want = distance_reports.pop_front();
          if (seen !== want) note_mismatch("wrong result", want, seen);
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  function automatic request_t make_req(logic [REQ_W-1:0] req, logic [VTX_W-1:0] tail,
                                        logic [VTX_W-1:0] head, logic signed [WGT_W-1:0] w,
                                        logic [VTX_W-1:0] src);
    request_t rq;
    rq.req = req;
    rq.tail = tail;
    rq.head = head;
    rq.weight = w;
    rq.src = src;
    return rq;
  endfunction

  function automatic stim_row_t item_row(logic [REQ_W-1:0] req, logic [VTX_W-1:0] tail,
                                         logic [VTX_W-1:0] head, logic signed [WGT_W-1:0] w,
                                         logic [VTX_W-1:0] src);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.rq = make_req(req, tail, head, w, src);
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg = v;
    return row;
  endfunction

  function automatic stim_row_t with_report(stim_row_t row, result_t res);
    row.typed = 1'b1;
    row.res = res;
    return row;
  endfunction

  function automatic result_t report(logic [VTX_W-1:0] v, logic [OUT_DIST_W-1:0] d,
                                     logic r, logic nc, logic l);
    result_t res;
    res.vertex = v;
    res.distance = d;
    res.reachable = r;
    res.negative_cycle = nc;
    res.last = l;
    return res;
  endfunction

  task automatic offer(input request_t rq, input logic typed, input result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    offered <= rq;
    offered_typed <= typed;
    offered_report <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (distance_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [CFG_W-1:0] v);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    stim_row_t plan [$];
    logic [CFG_W-1:0] cur_vc;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic [VTX_W-1:0] src;
    logic signed [WGT_W-1:0] w;
    int n;
    int k;
    int mode;
    int runs;
    int sent;
    int phase;

    plan.push_back(with_report(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd0),
                               report(6'd0, 22'd0, 1'b1, 1'b0, 1'b1)));
    plan.push_back(with_report(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd63),
                               report(6'd0, 22'd0, 1'b0, 1'b0, 1'b1)));
    plan.push_back(item_row(REQ_UNUSED, 6'd63, 6'd63, -16'sd1, 6'd63));
    plan.push_back(cfg_row(7'd0));
    plan.push_back(with_report(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd0),
                               report(6'd0, 22'd0, 1'b1, 1'b0, 1'b1)));
    plan.push_back(item_row(REQ_ADD, 6'd0, 6'd0, -16'sd1, 6'd0));
    plan.push_back(with_report(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd0),
                               report(6'd0, 22'd0, 1'b0, 1'b1, 1'b1)));
    plan.push_back(item_row(REQ_CLR, 6'd0, 6'd0, 16'sd0, 6'd0));
    plan.push_back(cfg_row(7'd4));
    plan.push_back(item_row(REQ_ADD, 6'd0, 6'd1, 16'sh7fff, 6'd0));
    plan.push_back(item_row(REQ_ADD, 6'd1, 6'd2, 16'sh8000, 6'd0));
    plan.push_back(item_row(REQ_ADD, 6'd2, 6'd3, 16'sd5, 6'd0));
    plan.push_back(item_row(REQ_ADD, 6'd3, 6'd63, 16'sd7, 6'd0));
    plan.push_back(item_row(REQ_ADD, 6'd63, 6'd0, 16'sd0, 6'd0));
    plan.push_back(item_row(REQ_ADD, 6'd2, 6'd0, 16'sh7fff, 6'd0));
    plan.push_back(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd0));
    plan.push_back(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd2));
    plan.push_back(cfg_row(7'd127));
    plan.push_back(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd63));
    plan.push_back(item_row(REQ_ADD, 6'd63, 6'd62, 16'sh8000, 6'd0));
    plan.push_back(cfg_row(7'd64));
    plan.push_back(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd63));
    plan.push_back(item_row(REQ_ADD, 6'd62, 6'd63, 16'sh7fff, 6'd0));
    plan.push_back(with_report(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd62),
                               report(6'd0, 22'd0, 1'b0, 1'b1, 1'b1)));
    plan.push_back(item_row(REQ_CLR, 6'd0, 6'd0, 16'sd0, 6'd0));
    plan.push_back(item_row(REQ_RUN, 6'd0, 6'd0, 16'sd0, 6'd5));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_vertex_count(plan[i].cfg);
      else offer(plan[i].rq, plan[i].typed, plan[i].res);
    end

    // overflow the edge table, then run over the full table
    set_vertex_count(7'd3);
    offer(make_req(REQ_CLR, '0, '0, '0, '0), 1'b0, '0);
    repeat (FILL_ITEMS) begin
      w = WGT_W'($urandom_range(300));
      offer(make_req(REQ_ADD, VTX_W'($urandom_range(3)), VTX_W'($urandom_range(3)), w,
                     VTX_W'($urandom_range(63))), 1'b0, '0);
    end
    offer(make_req(REQ_RUN, '0, '0, '0, VTX_W'($urandom_range(2))), 1'b0, '0);
    offer(make_req(REQ_CLR, '0, '0, '0, '0), 1'b0, '0);
    cur_vc = 7'd3;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = sent * 3 / RANDOM_ITEMS;
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 23 : 0;
      if ($urandom_range(4) < 3) begin
        case ($urandom_range(9))
          0: cur_vc = CFG_W'($urandom_range(127));
          1: begin
            case ($urandom_range(3))
              0: cur_vc = 7'd0;
              1: cur_vc = 7'd1;
              2: cur_vc = 7'd64;
              default: cur_vc = 7'd127;
            endcase
          end
          default: cur_vc = CFG_W'($urandom_range(2, 12));
        endcase
        set_vertex_count(cur_vc);
      end
      n = (cur_vc == 0) ? 1 : (cur_vc > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : cur_vc;
      if ($urandom_range(9) != 0) begin
        offer(make_req(REQ_CLR, VTX_W'($urandom_range(63)), VTX_W'($urandom_range(63)),
                       WGT_W'($urandom_range(65535)), VTX_W'($urandom_range(63))), 1'b0, '0);
        sent++;
      end
      mode = $urandom_range(2);
      k = $urandom_range((2 * n + 2 > 8) ? 8 : 2 * n + 2);
      repeat (k) begin
        if ($urandom_range(24) == 0)
          offer(make_req(REQ_UNUSED, VTX_W'($urandom_range(63)), VTX_W'($urandom_range(63)),
                         WGT_W'($urandom_range(65535)), VTX_W'($urandom_range(63))), 1'b0, '0);
        w = WGT_W'($urandom_range(65535));
        if ($urandom_range(7) == 0) begin
          a = VTX_W'($urandom_range(63));
          b = VTX_W'($urandom_range(63));
        end else if (mode == 0 && n > 1) begin
          a = VTX_W'($urandom_range(n - 2));
          b = VTX_W'($urandom_range(a + 1, n - 1));
        end else begin
          a = VTX_W'($urandom_range(n - 1));
          b = VTX_W'($urandom_range(n - 1));
          if (mode == 1) w = WGT_W'($urandom_range(3000));
        end
        offer(make_req(REQ_ADD, a, b, w, VTX_W'($urandom_range(63))), 1'b0, '0);
        sent++;
      end
      runs = $urandom_range(1, 2);
      if (phase == 2 && !hold_go) begin
        hold_go = 1'b1;
        runs = 2;
      end
      repeat (runs) begin
        src = ($urandom_range(7) == 0) ? VTX_W'($urandom_range(63))
                                       : VTX_W'($urandom_range(n - 1));
        offer(make_req(REQ_RUN, VTX_W'($urandom_range(63)), VTX_W'($urandom_range(63)),
                       WGT_W'($urandom_range(65535)), src), 1'b0, '0);
        sent++;
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
